/* hdl/psfp_pkg.sv */
// Shared types and constants for the particle sensor frame parser.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package psfp_pkg;

  localparam int unsigned REPORTED_WORDS = 12;
  localparam int unsigned WORD_W         = 16;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [7:0] HDR_B        = 8'h42;
  localparam logic [7:0] HDR_M        = 8'h4D;
  localparam logic [7:0] MEAS_LENGTH  = 8'd28;
  localparam logic [7:0] CTRL_LENGTH  = 8'd4;
  localparam logic [4:0] MEAS_LAST_POS = 5'(MEAS_LENGTH - 8'd3);
  localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(REPORTED_WORDS - 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [REPORTED_WORDS-1:0] payload_t;

  typedef enum logic [1:0] {
    KIND_MEAS = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_LEN_HIGH  = 2'd0,
    ERR_LEN_VALUE = 2'd1,
    ERR_CHECKSUM  = 2'd2
  } err_e;

  // One finished frame, handed from the parser to the result sequencer.
  typedef struct packed {
    kind_e kind;
    err_e  err;
    word_t value;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hdl/particle_sensor_frame_parser.sv */
// Top level of the particle sensor frame parser.
// Instantiates psfp_front, psfp_queue and psfp_back; depends on psfp_pkg.
//
// Usage:
//   Input channel: one received serial byte per request on rx_byte_i, with
//   in_valid_i / in_ready_o. Output channel: one result per request (kind,
//   error code, word index, word value, changed flag, last) with
//   out_valid_o / out_ready_i.
//   A control or error result passes through the frame queue and the output
//   register before it is presented. A good measurement frame first compares
//   its words with the last good frame; the 12 results then follow at one
//   per cycle while the receiver takes them.
//   The parser keeps accepting header, length and checksum bytes while a
//   measurement run drains; it holds in_ready_o low only on payload bytes of
//   a new measurement frame until the run in progress is finished, or when
//   the two-entry frame queue is full. A stalled receiver holds the current
//   result in the output register and freezes the run behind it.
//   Reset puts the parser in the header hunt, empties the queue and clears
//   the stored previous frame to all zero.
`timescale 1ns / 1ps

module particle_sensor_frame_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [1:0]                 error_code_o,
  output logic [psfp_pkg::IDX_W-1:0] word_index_o,
  output logic [15:0]                word_value_o,
  output logic                       changed_o,
  output logic                       last_o
);

  logic                meas_done;
  logic                push;
  logic                pop;
  psfp_pkg::job_t      push_job;
  psfp_pkg::job_t      head_job;
  psfp_pkg::q_status_t q_status;
  psfp_pkg::payload_t  payload;

  psfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .q_status_i  (q_status),
    .meas_done_i (meas_done),
    .push_o      (push),
    .job_o       (push_job),
    .payload_o   (payload)
  );

  psfp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  psfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .payload_i    (payload),
    .meas_done_o  (meas_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .changed_o    (changed_o),
    .last_o       (last_o)
  );

endmodule

/* hdl/psfp_front.sv */
// Byte parser: header hunt, length decode, payload capture and checksum check.
// Depends on psfp_pkg; feeds finished frames into psfp_queue.
`timescale 1ns / 1ps

module psfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  psfp_pkg::q_status_t q_status_i,
  input  logic                meas_done_i,
  output logic                push_o,
  output psfp_pkg::job_t      job_o,
  output psfp_pkg::payload_t  payload_o
);

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_LEN,
    PH_MEAS,
    PH_CTRL,
    PH_CKSUM
  } phase_e;

  phase_e             phase_q;
  logic [4:0]         pos_q;
  logic               is_ctrl_q;
  logic [15:0]        run_sum_q;
  logic [7:0]         rcv_hi_q;
  psfp_pkg::word_t    ctrl_word_q;
  logic               meas_busy_q;
  logic [7:0]         byte_hi_q;
  psfp_pkg::payload_t payload_q;

  logic                         accept;
  logic [15:0]                  sum_add;
  logic [psfp_pkg::IDX_W-1:0]   word_idx;

  // The payload store belongs to the sequencer until it has drained a run.
  assign in_ready_o = !q_status_i.full && !((phase_q == PH_MEAS) && meas_busy_q);
  assign accept     = in_valid_i && in_ready_o;
  assign sum_add    = run_sum_q + {8'd0, rx_byte_i};
  assign word_idx   = pos_q[4:1];
  assign payload_o  = payload_q;

  always_comb begin
    push_o       = 1'b0;
    job_o.kind   = psfp_pkg::KIND_ERR;
    job_o.err    = psfp_pkg::ERR_LEN_HIGH;
    job_o.value  = '0;
    if (accept) begin
      case (phase_q)
        PH_LEN: begin
          if (pos_q == 5'd0) begin
            if (rx_byte_i != 8'd0) begin
              push_o    = 1'b1;
              job_o.err = psfp_pkg::ERR_LEN_HIGH;
            end
          end else if (rx_byte_i != psfp_pkg::MEAS_LENGTH &&
                       rx_byte_i != psfp_pkg::CTRL_LENGTH) begin
            push_o    = 1'b1;
            job_o.err = psfp_pkg::ERR_LEN_VALUE;
          end
        end
        PH_CKSUM: begin
          if (pos_q != 5'd0) begin
            push_o = 1'b1;
            if ({rcv_hi_q, rx_byte_i} != run_sum_q) begin
              job_o.err = psfp_pkg::ERR_CHECKSUM;
            end else if (is_ctrl_q) begin
              job_o.kind  = psfp_pkg::KIND_CTRL;
              job_o.value = ctrl_word_q;
            end else begin
              job_o.kind = psfp_pkg::KIND_MEAS;
            end
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR1;
      pos_q       <= '0;
      is_ctrl_q   <= 1'b0;
      run_sum_q   <= '0;
      rcv_hi_q    <= '0;
      ctrl_word_q <= '0;
      meas_busy_q <= 1'b0;
    end else begin
      if (push_o && job_o.kind == psfp_pkg::KIND_MEAS) begin
        meas_busy_q <= 1'b1;
      end else if (meas_done_i) begin
        meas_busy_q <= 1'b0;
      end
      if (accept) begin
        case (phase_q)
          PH_HDR2: begin
            if (rx_byte_i == psfp_pkg::HDR_M) begin
              run_sum_q <= sum_add;
              phase_q   <= PH_LEN;
              pos_q     <= '0;
            end else begin
              phase_q <= PH_HDR1;
            end
          end
          PH_LEN: begin
            run_sum_q <= sum_add;
            if (pos_q == 5'd0) begin
              if (rx_byte_i != 8'd0) begin
                phase_q <= PH_HDR1;
              end else begin
                pos_q <= 5'd1;
              end
            end else begin
              pos_q <= '0;
              if (rx_byte_i == psfp_pkg::MEAS_LENGTH) begin
                phase_q   <= PH_MEAS;
                is_ctrl_q <= 1'b0;
              end else if (rx_byte_i == psfp_pkg::CTRL_LENGTH) begin
                phase_q   <= PH_CTRL;
                is_ctrl_q <= 1'b1;
              end else begin
                phase_q <= PH_HDR1;
              end
            end
          end
          PH_MEAS: begin
            run_sum_q <= sum_add;
            if (pos_q == psfp_pkg::MEAS_LAST_POS) begin
              phase_q <= PH_CKSUM;
              pos_q   <= '0;
            end else begin
              pos_q <= pos_q + 5'd1;
            end
          end
          PH_CTRL: begin
            run_sum_q <= sum_add;
            if (pos_q == 5'd0) begin
              ctrl_word_q <= {rx_byte_i, 8'd0};
              pos_q       <= 5'd1;
            end else begin
              ctrl_word_q <= {ctrl_word_q[15:8], rx_byte_i};
              phase_q     <= PH_CKSUM;
              pos_q       <= '0;
            end
          end
          PH_CKSUM: begin
            if (pos_q == 5'd0) begin
              rcv_hi_q <= rx_byte_i;
              pos_q    <= 5'd1;
            end else begin
              phase_q <= PH_HDR1;
              pos_q   <= '0;
            end
          end
          default: begin
            // Header one hunt; a stray byte just keeps hunting.
            pos_q <= '0;
            if (rx_byte_i == psfp_pkg::HDR_B) begin
              run_sum_q <= {8'd0, rx_byte_i};
              phase_q   <= PH_HDR2;
            end else begin
              phase_q <= PH_HDR1;
            end
          end
        endcase
      end
    end
  end

  // Payload words; the thirteenth word only enters the checksum.
  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PH_MEAS &&
        word_idx < psfp_pkg::IDX_W'(psfp_pkg::REPORTED_WORDS)) begin
      if (!pos_q[0]) begin
        byte_hi_q <= rx_byte_i;
      end else begin
        payload_q[word_idx] <= {byte_hi_q, rx_byte_i};
      end
    end
  end

endmodule

/* hdl/psfp_queue.sv */
// Two-entry job queue between the byte parser and the result sequencer.
// Depends on psfp_pkg for the job type.
`timescale 1ns / 1ps

module psfp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  psfp_pkg::job_t      job_i,
  input  logic                pop_i,
  output psfp_pkg::job_t      job_o,
  output psfp_pkg::q_status_t status_o
);

  psfp_pkg::job_t [psfp_pkg::QUEUE_DEPTH-1:0] mem_q;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign job_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'(psfp_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* hdl/psfp_back.sv */
// Result sequencer: compares a measurement frame with the last good one and
// emits results through an output register. Depends on psfp_pkg.
`timescale 1ns / 1ps

module psfp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  psfp_pkg::job_t             job_i,
  input  psfp_pkg::q_status_t        q_status_i,
  output logic                       pop_o,
  input  psfp_pkg::payload_t         payload_i,
  output logic                       meas_done_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [1:0]                 error_code_o,
  output logic [psfp_pkg::IDX_W-1:0] word_index_o,
  output psfp_pkg::word_t            word_value_o,
  output logic                       changed_o,
  output logic                       last_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_CMP,
    B_EMIT
  } state_e;

  state_e                     state_q;
  logic [psfp_pkg::IDX_W-1:0] idx_q;
  logic                       chg_q;
  psfp_pkg::payload_t         prev_q;

  logic                       out_valid_q;
  psfp_pkg::kind_e            kind_q;
  psfp_pkg::err_e             err_q;
  logic [psfp_pkg::IDX_W-1:0] index_q;
  psfp_pkg::word_t            value_q;
  logic                       changed_q;
  logic                       last_q;

  logic slot_free;
  logic load_out;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == B_IDLE) && !q_status_i.empty &&
                       (job_i.kind == psfp_pkg::KIND_MEAS || slot_free);
  assign meas_done_o = (state_q == B_EMIT) && slot_free && (idx_q == psfp_pkg::LAST_WORD);
  assign load_out    = (pop_o && job_i.kind != psfp_pkg::KIND_MEAS) ||
                       ((state_q == B_EMIT) && slot_free);

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign error_code_o = err_q;
  assign word_index_o = index_q;
  assign word_value_o = value_q;
  assign changed_o    = changed_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      idx_q       <= '0;
      chg_q       <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= psfp_pkg::KIND_MEAS;
      err_q       <= psfp_pkg::ERR_LEN_HIGH;
      index_q     <= '0;
      value_q     <= '0;
      changed_q   <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (job_i.kind == psfp_pkg::KIND_MEAS) begin
              state_q <= B_CMP;
              idx_q   <= '0;
              chg_q   <= 1'b0;
            end else begin
              kind_q      <= job_i.kind;
              err_q       <= job_i.err;
              index_q     <= '0;
              value_q     <= job_i.value;
              changed_q   <= 1'b0;
              last_q      <= 1'b1;
            end
          end
        end
        B_CMP: begin
          // One word per cycle against the last good frame.
          if (payload_i[idx_q] != prev_q[idx_q]) begin
            chg_q <= 1'b1;
          end
          if (idx_q == psfp_pkg::LAST_WORD) begin
            idx_q   <= '0;
            state_q <= B_EMIT;
          end else begin
            idx_q <= idx_q + psfp_pkg::IDX_W'(1);
          end
        end
        B_EMIT: begin
          if (slot_free) begin
            kind_q      <= psfp_pkg::KIND_MEAS;
            err_q       <= psfp_pkg::ERR_LEN_HIGH;
            index_q     <= idx_q;
            value_q     <= payload_i[idx_q];
            changed_q   <= chg_q;
            last_q      <= (idx_q == psfp_pkg::LAST_WORD);
            if (chg_q) begin
              prev_q[idx_q] <= payload_i[idx_q];
            end
            if (idx_q == psfp_pkg::LAST_WORD) begin
              idx_q   <= '0;
              state_q <= B_IDLE;
            end else begin
              idx_q <= idx_q + psfp_pkg::IDX_W'(1);
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* bench/psfp_frame_checker.sv */
// Watches both request channels of the particle sensor frame parser, predicts
// the results of every accepted byte and compares them in order.
// Depends on psfp_pkg.
`timescale 1ns / 1ps

module psfp_frame_checker
  import psfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  error_code_i,
  input  logic [3:0]  word_index_i,
  input  logic [15:0] word_value_i,
  input  logic        changed_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          outstanding_o,
  output int          checked_o
);

  typedef enum logic [2:0] {
    HUNT_B,
    HUNT_M,
    LENGTH_FIELD,
    MEAS_BODY,
    CTRL_BODY,
    CHECKSUM_FIELD
  } parse_phase_e;

  typedef struct {
    kind_e      kind;
    err_e       err;
    logic [3:0] idx;
    word_t      value;
    logic       changed;
    logic       last;
  } frame_result_t;

  localparam logic [4:0] BODY_BYTES = 5'(MEAS_LENGTH - 8'd2);

  parse_phase_e  phase;
  logic [4:0]    pos;
  logic          is_ctrl;
  logic [15:0]   run_sum;
  logic [15:0]   recv_sum;
  word_t         ctrl_word;
  word_t         body [REPORTED_WORDS];
  word_t         prev_body [REPORTED_WORDS];
  frame_result_t frame_results [$];
  int            fails;
  int            checked;

  task automatic note_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fails++;
  endtask

  task automatic queue_result(input kind_e kind, input err_e err, input logic [3:0] idx,
                              input word_t value, input logic chg, input logic lst);
    frame_result_t r;
    r.kind    = kind;
    r.err     = err;
    r.idx     = idx;
    r.value   = value;
    r.changed = chg;
    r.last    = lst;
    frame_results.insert(frame_results.size(), r);
  endtask

  task automatic frame_error(input err_e code);
    phase = HUNT_B;
    pos   = '0;
    queue_result(KIND_ERR, code, 4'd0, 16'h0000, 1'b0, 1'b1);
  endtask

  // Advances the parser model by one received byte.
  task automatic parse_byte(input logic [7:0] b);
    int   slot;
    logic chg;
    case (phase)
      HUNT_M: begin
        if (b == HDR_M) begin
          run_sum = run_sum + 16'(b);
          phase   = LENGTH_FIELD;
          pos     = '0;
        end else begin
          phase = HUNT_B;
        end
      end
      LENGTH_FIELD: begin
        run_sum = run_sum + 16'(b);
        if (pos == 0) begin
          if (b != 8'd0) frame_error(ERR_LEN_HIGH);
          else pos = 5'd1;
        end else begin
          pos = '0;
          if (b == MEAS_LENGTH) begin
            phase   = MEAS_BODY;
            is_ctrl = 1'b0;
          end else if (b == CTRL_LENGTH) begin
            phase   = CTRL_BODY;
            is_ctrl = 1'b1;
          end else begin
            frame_error(ERR_LEN_VALUE);
          end
        end
      end
      MEAS_BODY: begin
        run_sum = run_sum + 16'(b);
        slot = int'(pos >> 1);
        // The reserved 13th word only enters the checksum.
        if (slot < REPORTED_WORDS) begin
          if (!pos[0]) body[slot] = {b, 8'h00};
          else body[slot][7:0] = b;
        end
        pos = pos + 5'd1;
        if (pos >= BODY_BYTES) begin
          phase = CHECKSUM_FIELD;
          pos   = '0;
        end
      end
      CTRL_BODY: begin
        run_sum = run_sum + 16'(b);
        if (pos == 0) begin
          ctrl_word = {b, 8'h00};
          pos       = 5'd1;
        end else begin
          ctrl_word[7:0] = b;
          phase          = CHECKSUM_FIELD;
          pos            = '0;
        end
      end
      CHECKSUM_FIELD: begin
        if (pos == 0) begin
          recv_sum = {b, 8'h00};
          pos      = 5'd1;
        end else begin
          recv_sum[7:0] = b;
          if (recv_sum != run_sum) begin
            frame_error(ERR_CHECKSUM);
          end else begin
            phase = HUNT_B;
            pos   = '0;
            if (is_ctrl) begin
              queue_result(KIND_CTRL, ERR_LEN_HIGH, 4'd0, ctrl_word, 1'b0, 1'b1);
            end else begin
              chg = 1'b0;
              for (int k = 0; k < REPORTED_WORDS; k++)
                if (body[k] != prev_body[k]) chg = 1'b1;
              if (chg)
                for (int k = 0; k < REPORTED_WORDS; k++) prev_body[k] = body[k];
              for (int k = 0; k < REPORTED_WORDS; k++)
                queue_result(KIND_MEAS, ERR_LEN_HIGH, 4'(k), body[k], chg,
                             k == REPORTED_WORDS - 1);
            end
          end
        end
      end
      default: begin
        phase = HUNT_B;
        if (b == HDR_B) begin
          run_sum = 16'(b);
          phase   = HUNT_M;
        end
        pos = '0;
      end
    endcase
  endtask

  task automatic compare_result();
    frame_result_t exp;
    if (frame_results.size() == 0) begin
      note_mismatch($sformatf("result with nothing expected (kind %0d value %h)",
                              kind_i, word_value_i));
    end else begin
      exp = frame_results.pop_front();
      checked++;
      if (kind_i !== exp.kind)
        note_mismatch($sformatf("kind %0d, expected %0d", kind_i, exp.kind));
      if (error_code_i !== exp.err)
        note_mismatch($sformatf("error_code %0d, expected %0d", error_code_i, exp.err));
      if (word_index_i !== exp.idx)
        note_mismatch($sformatf("word_index %0d, expected %0d", word_index_i, exp.idx));
      if (word_value_i !== exp.value)
        note_mismatch($sformatf("word_value %h, expected %h", word_value_i, exp.value));
      if (changed_i !== exp.changed)
        note_mismatch($sformatf("changed %b, expected %b", changed_i, exp.changed));
      if (last_i !== exp.last)
        note_mismatch($sformatf("last %b, expected %b", last_i, exp.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase     = HUNT_B;
      pos       = '0;
      is_ctrl   = 1'b0;
      run_sum   = '0;
      recv_sum  = '0;
      ctrl_word = '0;
      for (int k = 0; k < REPORTED_WORDS; k++) begin
        body[k]      = '0;
        prev_body[k] = '0;
      end
      frame_results.delete();
    end else begin
      // A byte's results never leave on the edge that accepts it.
      if (out_valid_i && out_ready_i) compare_result();
      if (in_valid_i && in_ready_i) parse_byte(rx_byte_i);
    end
    fail_count_o  <= fails;
    outstanding_o <= frame_results.size();
    checked_o     <= checked;
  end

  initial begin
    fails   = 0;
    checked = 0;
  end

endmodule

/* bench/particle_sensor_frame_parser_test.sv */
// Testbench top for the particle sensor frame parser: builds the byte stream,
// drives both request channels and gives the verdict.
// Depends on psfp_pkg, particle_sensor_frame_parser and psfp_frame_checker.
`timescale 1ns / 1ps

module particle_sensor_frame_parser_test;
  import psfp_pkg::*;

  localparam int TOTAL_BYTES  = 460;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic [3:0]  word_index;
  logic [15:0] word_value;
  logic        changed;
  logic        last;
  int          fail_count;
  int          outstanding;
  int          checked;

  logic [7:0]  byte_stream [$];
  word_t       body_words [13];
  word_t       last_body [13];
  int          send_idle_pct = 10;
  int          recv_idle_pct = 76;
  int          stall_cycles = 0;
  int          meas_frames = 0;
  int          ctrl_frames = 0;
  int          broken_frames = 0;

  always #5 clk = ~clk;

  particle_sensor_frame_parser i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .error_code_o (error_code),
    .word_index_o (word_index),
    .word_value_o (word_value),
    .changed_o    (changed),
    .last_o       (last)
  );

  psfp_frame_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .kind_i        (kind),
    .error_code_i  (error_code),
    .word_index_i  (word_index),
    .word_value_i  (word_value),
    .changed_i     (changed),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("particle_sensor_frame_parser verification failed");
      $finish;
    end
  end

  task automatic append_byte(input logic [7:0] b);
    byte_stream.insert(byte_stream.size(), b);
  endtask

  // Appends a frame with the given length field; body_words supplies the
  // payload, and sum_flip nonzero corrupts the checksum.
  task automatic add_frame(input logic [7:0] len_lo, input int n_words,
                           input logic [15:0] sum_flip);
    logic [15:0] sum;
    sum = 16'(HDR_B) + 16'(HDR_M) + 16'(len_lo);
    append_byte(HDR_B);
    append_byte(HDR_M);
    append_byte(8'h00);
    append_byte(len_lo);
    for (int k = 0; k < n_words; k++) begin
      append_byte(body_words[k][15:8]);
      append_byte(body_words[k][7:0]);
      sum = sum + 16'(body_words[k][15:8]) + 16'(body_words[k][7:0]);
    end
    sum = sum ^ sum_flip;
    append_byte(sum[15:8]);
    append_byte(sum[7:0]);
    if (sum_flip != 0) broken_frames++;
    else if (n_words == 1) ctrl_frames++;
    else meas_frames++;
  endtask

  task automatic fill_body(input word_t fill);
    for (int k = 0; k < 13; k++) body_words[k] = fill;
  endtask

  task automatic random_meas(input logic [15:0] sum_flip);
    int pick;
    if ($urandom_range(0, 99) < 25) begin
      // Same words as the last measurement frame built, so it reports unchanged if that frame was good.
      for (int k = 0; k < 13; k++) body_words[k] = last_body[k];
    end else begin
      for (int k = 0; k < 13; k++) begin
        pick = $urandom_range(0, 9);
        body_words[k] = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      end
    end
    for (int k = 0; k < 13; k++) last_body[k] = body_words[k];
    add_frame(MEAS_LENGTH, 13, sum_flip);
  endtask

  task automatic build_random_frame();
    int          pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      random_meas(16'h0000);
    end else if (pick < 65) begin
      body_words[0] = 16'($urandom);
      add_frame(CTRL_LENGTH, 1, 16'h0000);
    end else if (pick < 75) begin
      random_meas(16'($urandom_range(1, 65535)));
    end else if (pick < 80) begin
      body_words[0] = 16'($urandom);
      add_frame(CTRL_LENGTH, 1, 16'($urandom_range(1, 65535)));
    end else if (pick < 85) begin
      do b = 8'($urandom); while (b == MEAS_LENGTH || b == CTRL_LENGTH);
      append_byte(HDR_B);
      append_byte(HDR_M);
      append_byte(8'h00);
      append_byte(b);
      broken_frames++;
    end else if (pick < 90) begin
      append_byte(HDR_B);
      append_byte(HDR_M);
      append_byte(8'($urandom_range(1, 255)));
      append_byte(8'($urandom));
      broken_frames++;
    end else if (pick < 95) begin
      do b = 8'($urandom); while (b == HDR_M);
      append_byte(HDR_B);
      append_byte(b);
    end else begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
    end
  endtask

  // Holds the byte request until the parser takes it; gaps come only
  // before valid is raised.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int total;

    // Header mismatches; the second 'B' is not a new start.
    append_byte(HDR_B);
    append_byte(8'h58);
    append_byte(HDR_M);
    append_byte(HDR_B);
    append_byte(HDR_B);
    append_byte(HDR_M);
    // Length high byte nonzero, then a length that is neither 28 nor 4.
    append_byte(HDR_B);
    append_byte(HDR_M);
    append_byte(8'hFF);
    append_byte(8'h00);
    append_byte(HDR_B);
    append_byte(HDR_M);
    append_byte(8'h00);
    append_byte(8'hFF);
    broken_frames += 2;
    // Control frames at both word extremes, and one with a bad checksum.
    body_words[0] = 16'hFFFF;
    add_frame(CTRL_LENGTH, 1, 16'h0000);
    body_words[0] = 16'h0000;
    add_frame(CTRL_LENGTH, 1, 16'h0000);
    add_frame(CTRL_LENGTH, 1, 16'h8001);
    // An all-zero first measurement reports unchanged; all ones then changes.
    fill_body(16'h0000);
    add_frame(MEAS_LENGTH, 13, 16'h0000);
    fill_body(16'hFFFF);
    add_frame(MEAS_LENGTH, 13, 16'h0000);
    for (int k = 0; k < 13; k++) last_body[k] = body_words[k];

    while (byte_stream.size() < TOTAL_BYTES) build_random_frame();
    total = byte_stream.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < total; k++) begin
      if (k == total / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 10;
      end else if (k == 2 * total / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_byte(byte_stream[k]);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes under three idle profiles: %0d measurement, %0d control,",
             total, meas_frames, ctrl_frames);
    $display("%0d malformed frames; %0d results compared.", broken_frames, checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("particle_sensor_frame_parser verification clean");
    end else begin
      $display("particle_sensor_frame_parser verification failed");
    end
    $finish;
  end

endmodule
